### design/mvab_pkg.sv
// Shared types and constants for the mesh vertex adjacency builder.
`default_nettype none

package mvab_pkg;

   // default sizes
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int MAX_CELLS_DEF    = 512;
   localparam int MAX_SIDES_DEF    = 16;

   // request commands
   typedef enum logic [1:0] {
      CMD_ADD       = 2'd0,
      CMD_READ_VTX  = 2'd1,
      CMD_READ_CELL = 2'd2,
      CMD_RESTART   = 2'd3
   } mvab_cmd_type;

   // response status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_INDEX = 3'd1,
      ST_TOO_LONG  = 3'd2,
      ST_TOO_MANY  = 3'd3,
      ST_TOO_SHORT = 3'd4,
      ST_NBR_OVER  = 3'd5,
      ST_OWN_OVER  = 3'd6
   } mvab_status_type;

   // one vertex row: up to three neighbours and three owning cells
   typedef struct packed {
      logic [1:0]       nbr_cnt;
      logic [2:0][9:0]  nbr;
      logic [1:0]       own_cnt;
      logic [2:0][8:0]  own;
   } mvab_row_type;

   // vertex unit operations
   typedef enum logic [1:0] {
      VOP_READ   = 2'd0,
      VOP_CLEAR  = 2'd1,
      VOP_UPDATE = 2'd2
   } mvab_vop_type;

   // overflow flags of one vertex update
   typedef struct packed {
      logic nbr_over;
      logic own_over;
   } mvab_flag_type;

endpackage

`default_nettype wire

### design/mvab_vertex_unit.sv
// Vertex row memory with the shared neighbour/owner merge unit.
`default_nettype none

module mvab_vertex_unit import mvab_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   localparam int VAW = $clog2(MAX_VERTICES)
) (
   input  wire logic           clock,
   input  wire mvab_vop_type   op,
   input  wire logic [VAW-1:0] addr,
   input  wire logic [9:0]     prev,
   input  wire logic [9:0]     next,
   input  wire logic [8:0]     owner,
   output mvab_row_type        row,
   output mvab_flag_type       flags
);

   typedef struct packed {
      mvab_row_type row;
      logic         over;
   } add_res_type;

   mvab_row_type mem [MAX_VERTICES];
   mvab_row_type rdata_ff;
   mvab_row_type merged;
   add_res_type  res_prev;
   add_res_type  res_next;

   // append a distinct neighbour, flag when the row is full
   function automatic add_res_type add_nbr(mvab_row_type r, logic [9:0] n);
      add_res_type res;
      logic        hit;
      res.row  = r;
      res.over = 1'b0;
      hit      = 1'b0;
      for (int j = 0; j < 3; j++) begin
         if ((2'(j) < r.nbr_cnt) && (r.nbr[j] == n)) begin
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (r.nbr_cnt == 2'd3) begin
            res.over = 1'b1;
         end else begin
            res.row.nbr[r.nbr_cnt] = n;
            res.row.nbr_cnt        = r.nbr_cnt + 2'd1;
         end
      end
      return res;
   endfunction

   // merge: previous, then next, then owning cell
   always_comb begin
      res_prev = add_nbr(rdata_ff, prev);
      res_next = add_nbr(res_prev.row, next);
      merged   = res_next.row;
      flags.nbr_over = res_prev.over | res_next.over;
      flags.own_over = 1'b0;
      if (merged.own_cnt == 2'd3) begin
         flags.own_over = 1'b1;
      end else begin
         merged.own[merged.own_cnt] = owner;
         merged.own_cnt             = merged.own_cnt + 2'd1;
      end
   end

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (op == VOP_CLEAR) begin
         mem[addr] <= '0;
      end else if (op == VOP_UPDATE) begin
         mem[addr] <= merged;
      end
      rdata_ff <= mem[addr];
   end

   assign row = rdata_ff;

endmodule

`default_nettype wire

### design/mesh_vertex_adjacency_builder_core.sv
// Top level: command sequencer, pending cell buffer and cell stores.
// Add vertex (not last) and restart answer in the cycle after accept, queries after their
// query state. A last vertex committing a cell answers after S_C_PREV, S_C_CUR and an
// S_W_RD/S_W_UPD pair per vertex: every vertex takes one read and one read-modify-write of
// the single-ported vertex row memory. Reset and restart clear every vertex row; busy stays
// high meanwhile. Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module mesh_vertex_adjacency_builder_core import mvab_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_CELLS    = MAX_CELLS_DEF,
   parameter int MAX_SIDES    = MAX_SIDES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [9:0]  req_vertex_index,
   input  wire logic        req_last_in_cell,
   input  wire logic [8:0]  req_cell_index,
   input  wire logic [3:0]  req_slot,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [9:0]       rsp_neighbour_a,
   output logic [9:0]       rsp_neighbour_b,
   output logic [9:0]       rsp_neighbour_c,
   output logic [1:0]       rsp_neighbour_total,
   output logic [8:0]       rsp_owner_a,
   output logic [8:0]       rsp_owner_b,
   output logic [8:0]       rsp_owner_c,
   output logic [1:0]       rsp_owner_total,
   output logic [9:0]       rsp_cell_vertex,
   output logic [4:0]       rsp_cell_sides,
   input  wire logic        csr_wr_en,
   input  wire logic [10:0] csr_wr_data
);

   localparam int VAW  = $clog2(MAX_VERTICES);
   localparam int CAW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int SAW  = $clog2(MAX_SIDES);
   localparam int FW   = $clog2(MAX_SIDES + 1);
   localparam int CNW  = $clog2(MAX_CELLS + 1);
   localparam int VLW  = $clog2(MAX_VERTICES + 1);
   localparam int VCW  = (VLW > 11) ? VLW : 11;
   localparam int CCW  = (CNW > 9) ? CNW : 9;
   localparam int QSW  = (FW > 4) ? FW : 4;
   localparam int SDEP = MAX_CELLS * (2 ** SAW);

   typedef enum logic [2:0] {
      S_IDLE, S_Q_VTX, S_Q_CELL, S_C_PREV, S_C_CUR, S_W_RD, S_W_UPD, S_CLEAR
   } state_type;

   state_type       state_ff, state_in;
   logic [10:0]     vcount_ff;
   logic [FW-1:0]   fill_ff, fill_in, n_ff, n_in;
   mvab_status_type err_ff, err_in;
   logic [CNW-1:0]  seen_ff, seen_in;
   logic [CAW-1:0]  cell_ff, cell_in;
   logic [SAW-1:0]  i_ff, i_in;
   logic [9:0]      prev_ff, prev_in, cur_ff, cur_in, next_ff, next_in;
   logic            nover_ff, nover_in, oover_ff, oover_in;
   logic            qbad_ff, qbad_in;
   logic [3:0]      slot_ff, slot_in;
   logic [VAW-1:0]  clr_ff, clr_in;

   logic            rsp_valid_ff, rsp_valid_in;
   mvab_status_type status_ff, status_in;
   logic [2:0][9:0] nbr_ff, nbr_in;
   logic [1:0]      ntot_ff, ntot_in;
   logic [2:0][8:0] own_ff, own_in;
   logic [1:0]      otot_ff, otot_in;
   logic [9:0]      cvert_ff, cvert_in;
   logic [4:0]      csides_ff, csides_in;

   logic [9:0]      pend_ff [MAX_SIDES];
   logic [9:0]      store_mem [SDEP];
   logic [FW-1:0]   sides_mem [MAX_CELLS];
   logic [9:0]      store_q_ff;
   logic [FW-1:0]   sides_q_ff;

   mvab_cmd_type    cmd;
   logic            accept, vbad, add_ok;
   mvab_status_type add_st, last_st;
   logic            commit;
   logic [SAW-1:0]  buf_idx;
   logic [9:0]      buf_q;
   mvab_vop_type    vop;
   logic [VAW-1:0]  vaddr;
   mvab_row_type    row;
   mvab_flag_type   flags;

   assign cmd    = mvab_cmd_type'(req_cmd);
   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // vertex range check against min(vertex_count, MAX_VERTICES)
   assign vbad = (VCW'(req_vertex_index) >= VCW'(vcount_ff)) ||
                 (VCW'(req_vertex_index) >= VCW'(MAX_VERTICES));

   // add-vertex decision
   always_comb begin
      add_ok = 1'b0;
      if (vbad) begin
         add_st = ST_BAD_INDEX;
      end else if (fill_ff >= FW'(MAX_SIDES)) begin
         add_st = ST_TOO_LONG;
      end else begin
         add_st = ST_OK;
         add_ok = 1'b1;
      end
      fill_in = add_ok ? fill_ff + FW'(1) : fill_ff;
      err_in  = (err_ff == ST_OK) ? add_st : err_ff;
      commit  = 1'b0;
      last_st = ST_OK;
      if (err_in != ST_OK) begin
         last_st = err_in;
      end else if (fill_in < FW'(3)) begin
         last_st = ST_TOO_SHORT;
      end else if (seen_ff >= CNW'(MAX_CELLS)) begin
         last_st = ST_TOO_MANY;
      end else begin
         commit = 1'b1;
      end
   end

   // pending buffer read select
   always_comb begin
      case (state_ff)
         S_C_PREV: buf_idx = SAW'(n_ff - FW'(2));
         S_C_CUR:  buf_idx = SAW'(n_ff - FW'(1));
         default:  buf_idx = i_ff;
      endcase
   end
   assign buf_q = pend_ff[buf_idx];

   // pending buffer write
   always_ff @(posedge clock) begin
      if (accept && (cmd == CMD_ADD) && add_ok) begin
         pend_ff[SAW'(fill_ff)] <= req_vertex_index;
      end
   end

   // cell stores
   always_ff @(posedge clock) begin
      if (state_ff == S_W_RD) begin
         store_mem[{cell_ff, i_ff}] <= buf_q;
      end
      if (state_ff == S_C_CUR) begin
         sides_mem[cell_ff] <= n_ff;
      end
      store_q_ff <= store_mem[{CAW'(req_cell_index), SAW'(req_slot)}];
      sides_q_ff <= sides_mem[CAW'(req_cell_index)];
   end

   // vertex unit control
   always_comb begin
      case (state_ff)
         S_CLEAR: begin
            vop   = VOP_CLEAR;
            vaddr = clr_ff;
         end
         S_W_RD: begin
            vop   = VOP_READ;
            vaddr = VAW'(cur_ff);
         end
         S_W_UPD: begin
            vop   = VOP_UPDATE;
            vaddr = VAW'(cur_ff);
         end
         default: begin
            vop   = VOP_READ;
            vaddr = VAW'(req_vertex_index);
         end
      endcase
   end

   mvab_vertex_unit #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_vertex (
      .clock (clock),
      .op    (vop),
      .addr  (vaddr),
      .prev  (prev_ff),
      .next  (next_ff),
      .owner (9'(cell_ff)),
      .row   (row),
      .flags (flags)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      seen_in      = seen_ff;
      cell_in      = cell_ff;
      i_in         = i_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      next_in      = next_ff;
      nover_in     = nover_ff;
      oover_in     = oover_ff;
      qbad_in      = qbad_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      status_in    = ST_OK;
      nbr_in       = '0;
      ntot_in      = '0;
      own_in       = '0;
      otot_in      = '0;
      cvert_in     = '0;
      csides_in    = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (cmd)
                  CMD_ADD: begin
                     if (!req_last_in_cell) begin
                        rsp_valid_in = 1'b1;
                        status_in    = add_st;
                     end else if (commit) begin
                        n_in     = fill_in;
                        cell_in  = CAW'(seen_ff);
                        nover_in = 1'b0;
                        oover_in = 1'b0;
                        state_in = S_C_PREV;
                     end else begin
                        rsp_valid_in = 1'b1;
                        status_in    = last_st;
                     end
                  end
                  CMD_READ_VTX: begin
                     qbad_in  = vbad;
                     state_in = S_Q_VTX;
                  end
                  CMD_READ_CELL: begin
                     qbad_in  = (CCW'(req_cell_index) >= CCW'(seen_ff));
                     slot_in  = req_slot;
                     state_in = S_Q_CELL;
                  end
                  default: begin
                     seen_in      = '0;
                     clr_in       = '0;
                     rsp_valid_in = 1'b1;
                     state_in     = S_CLEAR;
                  end
               endcase
            end
         end
         S_Q_VTX: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (qbad_ff) begin
               status_in = ST_BAD_INDEX;
            end else begin
               for (int j = 0; j < 3; j++) begin
                  nbr_in[j] = (2'(j) < row.nbr_cnt) ? row.nbr[j] : 10'd0;
                  own_in[j] = (2'(j) < row.own_cnt) ? row.own[j] : 9'd0;
               end
               ntot_in = row.nbr_cnt;
               otot_in = row.own_cnt;
            end
         end
         S_Q_CELL: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (qbad_ff) begin
               status_in = ST_BAD_INDEX;
            end else begin
               csides_in = 5'(sides_q_ff);
               if (QSW'(slot_ff) >= QSW'(sides_q_ff)) begin
                  status_in = ST_BAD_INDEX;
               end else begin
                  cvert_in = store_q_ff;
               end
            end
         end
         S_C_PREV: begin
            prev_in  = buf_q;
            state_in = S_C_CUR;
         end
         S_C_CUR: begin
            cur_in   = buf_q;
            i_in     = '0;
            seen_in  = seen_ff + CNW'(1);
            state_in = S_W_RD;
         end
         S_W_RD: begin
            next_in  = buf_q;
            state_in = S_W_UPD;
         end
         S_W_UPD: begin
            nover_in = nover_ff | flags.nbr_over;
            oover_in = oover_ff | flags.own_over;
            prev_in  = cur_ff;
            cur_in   = next_ff;
            i_in     = i_ff + SAW'(1);
            if (FW'(i_ff) == n_ff - FW'(1)) begin
               rsp_valid_in = 1'b1;
               status_in    = nover_in ? ST_NBR_OVER : (oover_in ? ST_OWN_OVER : ST_OK);
               state_in     = S_IDLE;
            end else begin
               state_in = S_W_RD;
            end
         end
         S_CLEAR: begin
            clr_in = clr_ff + VAW'(1);
            if (clr_ff == VAW'(MAX_VERTICES - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         vcount_ff    <= 11'd1024;
         fill_ff      <= '0;
         err_ff       <= ST_OK;
         seen_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         seen_ff      <= seen_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (accept && (cmd == CMD_ADD)) begin
            if (req_last_in_cell) begin
               fill_ff <= '0;
               err_ff  <= ST_OK;
            end else begin
               fill_ff <= fill_in;
               err_ff  <= err_in;
            end
         end else if (accept && (cmd == CMD_RESTART)) begin
            fill_ff <= '0;
            err_ff  <= ST_OK;
         end
      end
      n_ff      <= n_in;
      cell_ff   <= cell_in;
      i_ff      <= i_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      next_ff   <= next_in;
      nover_ff  <= nover_in;
      oover_ff  <= oover_in;
      qbad_ff   <= qbad_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      nbr_ff    <= nbr_in;
      ntot_ff   <= ntot_in;
      own_ff    <= own_in;
      otot_ff   <= otot_in;
      cvert_ff  <= cvert_in;
      csides_ff <= csides_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_neighbour_a     = nbr_ff[0];
   assign rsp_neighbour_b     = nbr_ff[1];
   assign rsp_neighbour_c     = nbr_ff[2];
   assign rsp_neighbour_total = ntot_ff;
   assign rsp_owner_a         = own_ff[0];
   assign rsp_owner_b         = own_ff[1];
   assign rsp_owner_c         = own_ff[2];
   assign rsp_owner_total     = otot_ff;
   assign rsp_cell_vertex     = cvert_ff;
   assign rsp_cell_sides      = csides_ff;

`ifndef ASSERT_OFF
   // pending fill never passes the side limit
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_SIDES))
      else $error("pending fill beyond side limit");

   // stored cell count never passes the cell limit
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNW'(MAX_CELLS))
      else $error("cell count beyond cell limit");

   // a non-final vertex is answered in the next cycle
   a_add_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && (cmd == CMD_ADD) && !req_last_in_cell) |=> rsp_valid)
      else $error("missing answer to added vertex");

   // the walk stays inside the committed cell
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_W_UPD) |-> (FW'(i_ff) < n_ff))
      else $error("walk index beyond cell size");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
// Testbench for the mesh vertex adjacency builder: directed table, random cells, self-checking.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import mvab_pkg::*;

   localparam int NV = MAX_VERTICES_DEF;
   localparam int NC = MAX_CELLS_DEF;
   localparam int NS = MAX_SIDES_DEF;
   // commit of a full cell plus margin
   localparam int SETTLE = 2 + 2 * NS + 8;
   // clearing pass plus slowest commit, several times over
   localparam int STALL_LIMIT = 4 * (NV + SETTLE + 16);

   // one result item
   typedef struct {
      logic [2:0] status;
      logic [9:0] nbr_a, nbr_b, nbr_c;
      logic [1:0] nbr_total;
      logic [8:0] own_a, own_b, own_c;
      logic [1:0] own_total;
      logic [9:0] cell_vertex;
      logic [4:0] cell_sides;
   } mesh_rsp_t;

   // directed row; typed rows carry their expected status and totals
   typedef struct {
      mvab_cmd_type cmd;
      int           vtx;
      bit           last;
      int           cell_idx;
      int           slot;
      bit           typed;
      mvab_status_type st;
      int           ntot, otot, sides;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = '0;
   logic [9:0]  req_vertex_index = '0;
   logic        req_last_in_cell = 1'b0;
   logic [8:0]  req_cell_index = '0;
   logic [3:0]  req_slot = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_neighbour_a, rsp_neighbour_b, rsp_neighbour_c;
   logic [1:0]  rsp_neighbour_total;
   logic [8:0]  rsp_owner_a, rsp_owner_b, rsp_owner_c;
   logic [1:0]  rsp_owner_total;
   logic [9:0]  rsp_cell_vertex;
   logic [4:0]  rsp_cell_sides;
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;

   mesh_vertex_adjacency_builder_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the block state
   logic [9:0]  nbr_tab   [NV][3];
   int          nbr_cnt   [NV];
   logic [8:0]  own_tab   [NV][3];
   int          own_cnt   [NV];
   logic [9:0]  cell_store[NC][NS];
   int          cell_sides[NC];
   logic [9:0]  pend_buf  [NS];
   int          pend_fill, pend_err, cells_stored;
   int          vtx_limit;

   mesh_rsp_t   expected_rsps[$];
   int          fail_count = 0;
   int          stall_cycles = 0;
   bit          idle_on;

   function automatic void clear_mesh();
      for (int i = 0; i < NV; i++) begin
         nbr_cnt[i] = 0;
         own_cnt[i] = 0;
      end
      for (int i = 0; i < NC; i++) cell_sides[i] = 0;
      pend_fill = 0;
      pend_err = 0;
      cells_stored = 0;
   endfunction

   function automatic int usable();
      return vtx_limit < NV ? vtx_limit : NV;
   endfunction

   // append a distinct neighbour; returns 1 on overflow
   function automatic bit link_vertex(int v, logic [9:0] n);
      for (int j = 0; j < nbr_cnt[v]; j++)
         if (nbr_tab[v][j] == n) return 1'b0;
      if (nbr_cnt[v] >= 3) return 1'b1;
      nbr_tab[v][nbr_cnt[v]] = n;
      nbr_cnt[v]++;
      return 1'b0;
   endfunction

   // store the pending cell and walk it from the last vertex
   function automatic int commit_cell();
      int n, cell_num;
      bit nover, oover;
      logic [9:0] prev, cur, nxt;
      n = pend_fill;
      cell_num = cells_stored;
      nover = 0;
      oover = 0;
      for (int i = 0; i < n; i++) cell_store[cell_num][i] = pend_buf[i];
      cell_sides[cell_num] = n;
      cells_stored++;
      prev = pend_buf[n - 2];
      cur = pend_buf[n - 1];
      for (int i = 0; i < n; i++) begin
         nxt = pend_buf[i];
         nover |= link_vertex(cur, prev);
         nover |= link_vertex(cur, nxt);
         if (own_cnt[cur] < 3) begin
            own_tab[cur][own_cnt[cur]] = cell_num[8:0];
            own_cnt[cur]++;
         end else begin
            oover = 1;
         end
         prev = cur;
         cur = nxt;
      end
      return nover ? ST_NBR_OVER : (oover ? ST_OWN_OVER : ST_OK);
   endfunction

   function automatic mesh_rsp_t predict_mesh(mvab_cmd_type cmd, int v, bit last, int c, int s);
      mesh_rsp_t r;
      int st;
      r = '{default: '0};
      case (cmd)
         CMD_ADD: begin
            st = ST_OK;
            if (v >= usable()) st = ST_BAD_INDEX;
            else if (pend_fill >= NS) st = ST_TOO_LONG;
            else begin
               pend_buf[pend_fill] = v[9:0];
               pend_fill++;
            end
            if (st != ST_OK && pend_err == ST_OK) pend_err = st;
            if (last) begin
               if (pend_err != ST_OK) st = pend_err;
               else if (pend_fill < 3) st = ST_TOO_SHORT;
               else if (cells_stored >= NC) st = ST_TOO_MANY;
               else st = commit_cell();
               pend_fill = 0;
               pend_err = 0;
            end
            r.status = st[2:0];
         end
         CMD_READ_VTX: begin
            if (v >= usable()) begin
               r.status = ST_BAD_INDEX;
            end else begin
               if (nbr_cnt[v] > 0) r.nbr_a = nbr_tab[v][0];
               if (nbr_cnt[v] > 1) r.nbr_b = nbr_tab[v][1];
               if (nbr_cnt[v] > 2) r.nbr_c = nbr_tab[v][2];
               if (own_cnt[v] > 0) r.own_a = own_tab[v][0];
               if (own_cnt[v] > 1) r.own_b = own_tab[v][1];
               if (own_cnt[v] > 2) r.own_c = own_tab[v][2];
               r.nbr_total = nbr_cnt[v][1:0];
               r.own_total = own_cnt[v][1:0];
            end
         end
         CMD_READ_CELL: begin
            if (c >= cells_stored) begin
               r.status = ST_BAD_INDEX;
            end else begin
               r.cell_sides = cell_sides[c][4:0];
               if (s >= cell_sides[c]) r.status = ST_BAD_INDEX;
               else r.cell_vertex = cell_store[c][s];
            end
         end
         default: clear_mesh();
      endcase
      return r;
   endfunction

   // drive one item and wait for its accept; typed rows override the prediction
   task automatic send_item(mvab_cmd_type cmd, int v, bit last, int c, int s,
                            bit typed = 0, mesh_rsp_t typed_rsp = '{default: '0});
      mesh_rsp_t r;
      if (idle_on && $urandom_range(99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_vertex_index <= v[9:0];
      req_last_in_cell <= last;
      req_cell_index <= c[8:0];
      req_slot <= s[3:0];
      // busy is stable at the falling edge; accept happens at the next rising edge
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      r = predict_mesh(cmd, int'(v[9:0]), last, int'(c[8:0]), int'(s[3:0]));
      expected_rsps.push_back(typed ? typed_rsp : r);
   endtask

   // write the vertex limit once the block has gone quiet
   task automatic write_limit(int value);
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[10:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vtx_limit = value;
   endtask

   // one cell of random length, mostly over the given vertex pool
   task automatic send_cell(int pool, output int len);
      int v, pick;
      pick = $urandom_range(99);
      if (pick < 6) len = $urandom_range(1, 2);
      else if (pick < 12) len = $urandom_range(15, 18);
      else len = $urandom_range(3, 6);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 4) v = $urandom_range(NV - 1);
         else v = $urandom_range(pool - 1);
         send_item(CMD_ADD, v, i == len - 1, $urandom_range(NC - 1), $urandom_range(15));
      end
   endtask

   // one random phase under the current vertex limit
   task automatic random_phase(int items, int pool);
      int sent, pick, len;
      sent = 0;
      while (sent < items) begin
         idle_on = !(sent > items / 3 && sent < 2 * items / 3);
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_cell(pool, len);
            sent += len;
         end else begin
            if (pick < 78)
               send_item(CMD_READ_VTX, $urandom_range(99) < 70 ? $urandom_range(pool - 1)
                         : $urandom_range(NV - 1), $urandom_range(1), $urandom_range(NC - 1),
                         $urandom_range(15));
            else if (pick < 98)
               send_item(CMD_READ_CELL, $urandom_range(NV - 1), $urandom_range(1),
                         $urandom_range(cells_stored + 2), $urandom_range(15));
            else
               send_item(CMD_RESTART, $urandom_range(NV - 1), $urandom_range(1),
                         $urandom_range(NC - 1), $urandom_range(15));
            sent++;
         end
      end
   endtask

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      mesh_rsp_t e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result, status %0d", rsp_status);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("neighbour_a", e.nbr_a, rsp_neighbour_a);
            check_field("neighbour_b", e.nbr_b, rsp_neighbour_b);
            check_field("neighbour_c", e.nbr_c, rsp_neighbour_c);
            check_field("neighbour_total", e.nbr_total, rsp_neighbour_total);
            check_field("owner_a", e.own_a, rsp_owner_a);
            check_field("owner_b", e.own_b, rsp_owner_b);
            check_field("owner_c", e.own_c, rsp_owner_c);
            check_field("owner_total", e.own_total, rsp_owner_total);
            check_field("cell_vertex", e.cell_vertex, rsp_cell_vertex);
            check_field("cell_sides", e.cell_sides, rsp_cell_sides);
         end
      end
   end

   // watchdog on cycles without any accepted item or result
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   stim_row_t dir_rows[$];

   function automatic stim_row_t row(mvab_cmd_type cmd, int v, bit last, int c, int s,
                                     bit typed = 0, mvab_status_type st = ST_OK,
                                     int ntot = 0, int otot = 0, int sides = 0);
      stim_row_t t;
      t = '{cmd, v, last, c, s, typed, st, ntot, otot, sides};
      return t;
   endfunction

   initial begin
      mesh_rsp_t t;
      idle_on = 1;
      vtx_limit = NV;
      clear_mesh();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty mesh, one triangle, overflow on vertex 5, short cells, restart
      dir_rows = '{
         row(CMD_READ_VTX, 0, 0, 0, 0, 1, ST_OK),
         row(CMD_READ_VTX, NV - 1, 1, 0, 0, 1, ST_OK),
         row(CMD_READ_CELL, 0, 0, 0, 0, 1, ST_BAD_INDEX),
         row(CMD_ADD, 5, 0, 0, 0), row(CMD_ADD, 6, 0, 0, 0), row(CMD_ADD, 7, 1, 0, 0),
         row(CMD_READ_CELL, 0, 0, 0, 2),
         row(CMD_READ_CELL, 0, 0, 0, 3, 1, ST_BAD_INDEX, 0, 0, 3),
         row(CMD_ADD, 5, 0, 0, 0), row(CMD_ADD, 10, 0, 0, 0), row(CMD_ADD, 11, 1, 0, 0),
         row(CMD_ADD, 5, 0, 0, 0), row(CMD_ADD, 12, 0, 0, 0), row(CMD_ADD, 13, 1, 0, 0),
         row(CMD_ADD, 5, 0, 0, 0), row(CMD_ADD, 14, 0, 0, 0), row(CMD_ADD, 15, 1, 0, 0),
         row(CMD_READ_VTX, 5, 0, 0, 0),
         row(CMD_ADD, 8, 0, 0, 0, 1, ST_OK),
         row(CMD_ADD, 9, 1, 0, 0, 1, ST_TOO_SHORT),
         row(CMD_ADD, 2, 1, 0, 0, 1, ST_TOO_SHORT),
         row(CMD_RESTART, 0, 0, 0, 0, 1, ST_OK),
         row(CMD_READ_CELL, 0, 0, 0, 0, 1, ST_BAD_INDEX),
         row(CMD_READ_VTX, 5, 0, 0, 0, 1, ST_OK)
      };
      foreach (dir_rows[i]) begin
         t = '{default: '0};
         t.status = dir_rows[i].st;
         t.nbr_total = dir_rows[i].ntot[1:0];
         t.own_total = dir_rows[i].otot[1:0];
         t.cell_sides = dir_rows[i].sides[4:0];
         send_item(dir_rows[i].cmd, dir_rows[i].vtx, dir_rows[i].last, dir_rows[i].cell_idx,
                   dir_rows[i].slot, dir_rows[i].typed, t);
      end

      // random phases over several vertex limits, extremes included
      write_limit(NV);
      random_phase(200, 24);
      write_limit(0);
      random_phase(40, 8);
      write_limit(1);
      random_phase(40, 4);
      write_limit(2047);
      random_phase(200, 40);
      write_limit($urandom_range(4, 40));
      random_phase(150, 48);
      write_limit(NV);
      random_phase(240, NV);

      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
